// ----- rtl/ntc_pkg.sv -----
// Shared types, constants and stencil coefficient tables of the
// node-to-center interpolator. No dependencies.
`default_nettype none

package ntc_pkg;

  localparam int unsigned WinDepth  = 9;
  localparam int unsigned HeadDepth = 8;
  localparam int unsigned TapCount  = 9;
  localparam int unsigned BaseFrac  = 15;  // fraction bits of the tables below
  localparam int unsigned BaseCoefW = 18;
  localparam int unsigned IdxW      = 11;
  localparam int unsigned PosW      = 14;

  // configuration register indexes
  localparam logic [1:0] RegOrderHalf = 2'd0;
  localparam logic [1:0] RegIntervals = 2'd1;
  localparam logic [1:0] RegPeriodic  = 2'd2;

  typedef enum logic [1:0] {
    K_COPY,
    K_INNER,
    K_EDGE
  } kind_e;

  typedef logic signed [BaseCoefW-1:0] coef_t;

  // per-beat control that travels alongside the datapath
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic            last;
  } ctl_t;

  localparam coef_t InnerTab [4][8] = '{
    '{18'sd16384, 18'sd16384, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{-18'sd2048, 18'sd18432, 18'sd18432, -18'sd2048, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
    '{18'sd384, -18'sd3200, 18'sd19200, 18'sd19200, -18'sd3200, 18'sd384, 18'sd0, 18'sd0},
    '{-18'sd80, 18'sd784, -18'sd3920, 18'sd19600, 18'sd19600, -18'sd3920, 18'sd784,
      -18'sd80}
  };

  localparam coef_t EdgeTab [3][3][9] = '{
    '{
      '{18'sd8960, 18'sd35840, -18'sd17920, 18'sd7168, -18'sd1280, 18'sd0, 18'sd0,
        18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0}
    },
    '{
      '{18'sd7392, 18'sd44352, -18'sd36960, 18'sd29568, -18'sd15840, 18'sd4928,
        -18'sd672, 18'sd0, 18'sd0},
      '{-18'sd672, 18'sd12096, 18'sd30240, -18'sd13440, 18'sd6048, -18'sd1728,
        18'sd224, 18'sd0, 18'sd0},
      '{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0}
    },
    '{
      '{18'sd6435, 18'sd51480, -18'sd60060, 18'sd72072, -18'sd64350, 18'sd40040,
        -18'sd16380, 18'sd3960, -18'sd429},
      '{-18'sd429, 18'sd10296, 18'sd36036, -18'sd24024, 18'sd18018, -18'sd10296,
        18'sd4004, -18'sd936, 18'sd99},
      '{18'sd99, -18'sd1320, 18'sd13860, 18'sd27720, -18'sd11550, 18'sd5544,
        -18'sd1980, 18'sd440, -18'sd45}
    }
  };

  // coefficient of tap t; h is the effective half order (1..4), r the edge row
  function automatic coef_t ntc_coef(kind_e kind, logic [2:0] h, logic [1:0] r,
                                     logic [3:0] t);
    coef_t c;
    c = '0;
    case (kind)
      K_COPY:  c = (t == 4'd0) ? 18'sd32768 : 18'sd0;
      K_INNER: c = (t < 4'd8) ? InnerTab[h[1:0] - 2'd1][t[2:0]] : 18'sd0;
      K_EDGE:  c = (h >= 3'd2 && r != 2'd0) ? EdgeTab[h[1:0] - 2'd2][r - 2'd1][t] : 18'sd0;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/node_to_center_interpolator_core.sv -----
// Node-to-center interpolator: a stream of grid node samples in, a stream of
// interpolated cell-center rows out. Top level; uses ntc_pkg, ntc_seq, ntc_mac.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / node_value_i) takes node samples
//   in grid order, one beat per node. Output channel (out_valid_o /
//   out_stall_i) gives one beat per center with its row index; last_center_o
//   marks the final center of a grid pass. Config writes (cfg_valid_i,
//   cfg_index_i, cfg_data_i; cfg_ready_o always high) set order_half,
//   interval_count and periodic_mode, and restart the pass.
//   A row passes the tap, product, partial-sum and result registers; while
//   the output is not stalled, further rows of a burst follow one per cycle
//   and one node per cycle is taken where a node yields at most one row. A
//   node that ends a leading boundary or a pass yields up to k rows; the row
//   sequencer issues one row per cycle and holds the input for those cycles.
//   Reset clears the window, the node counter and the pipeline valids and
//   loads order_half 1, interval_count 64, non-periodic mode.
//   A stall on the output while out_valid_o is high freezes the whole
//   pipeline; in_stall_o rises in the same cycle.
`default_nettype none

module node_to_center_interpolator_core import ntc_pkg::*; #(
  parameter int unsigned MAX_INTERVALS  = 1024,
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned COEF_FRAC_BITS = 15
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [IdxW-1:0]                cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] node_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]      center_value_o,
  output logic [IdxW-1:0]                     center_index_o,
  output logic                                last_center_o
);

  logic [2:0]      order_half_q;
  logic [IdxW-1:0] interval_count_q;
  logic            periodic_q;
  logic            cfg_we, restart, en, more;
  logic [2:0]      h_eff;
  logic [IdxW-1:0] m_clamp, m_eff;

  logic signed [SAMPLE_WIDTH-1:0] tap [TapCount];
  coef_t                          coef [TapCount];
  ctl_t                           ctl;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && (cfg_index_i == RegOrderHalf ||
                                  cfg_index_i == RegIntervals ||
                                  cfg_index_i == RegPeriodic);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_half_q     <= 3'd1;
      interval_count_q <= IdxW'(64);
      periodic_q       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegOrderHalf: order_half_q     <= cfg_data_i[2:0];
        RegIntervals: interval_count_q <= cfg_data_i;
        RegPeriodic:  periodic_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    h_eff = order_half_q;
    if (h_eff < 3'd1) h_eff = 3'd1;
    if (h_eff > 3'd4) h_eff = 3'd4;
    m_clamp = (32'(interval_count_q) > MAX_INTERVALS) ? IdxW'(MAX_INTERVALS) : interval_count_q;
    m_eff   = (m_clamp <= IdxW'({h_eff, 2'b00})) ? IdxW'({h_eff, 2'b00}) + 1'b1 : m_clamp;
  end

  ntc_seq #(.SW(SAMPLE_WIDTH)) u_seq (
    .clk_i,
    .rst_ni,
    .en_i         (en),
    .restart_i    (restart),
    .h_i          (h_eff),
    .m_i          (m_eff),
    .periodic_i   (periodic_q),
    .in_valid_i,
    .in_stall_o,
    .node_value_i,
    .tap_o        (tap),
    .coef_o       (coef),
    .ctl_o        (ctl),
    .more_o       (more)
  );

  ntc_mac #(.SW(SAMPLE_WIDTH), .CF(COEF_FRAC_BITS)) u_mac (
    .clk_i,
    .rst_ni,
    .tap_i        (tap),
    .coef_i       (coef),
    .ctl_i        (ctl),
    .out_stall_i,
    .en_o         (en),
    .out_valid_o,
    .center_value_o,
    .center_index_o,
    .last_center_o
  );

`ifndef SYNTHESIS
  // input held while a multi-row burst is still being issued
  a_burst_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    more |-> in_stall_o) else $error("input taken during row burst");

  // non-periodic pass ends on row m+1
  a_last_row_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_center_o && !periodic_q |->
      center_index_o == IdxW'(m_eff + 1'b1)) else $error("bad final row index");

  // a frozen pipeline takes no new node
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o) else $error("input taken while frozen");
`endif

endmodule

`default_nettype wire

// ----- rtl/ntc_seq.sv -----
// Sample window, head store, node counter and the row sequencer that turns
// each accepted node into row jobs and fetches their nine taps. Uses ntc_pkg.
`default_nettype none

module ntc_seq import ntc_pkg::*; #(
  parameter int unsigned SW = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 restart_i,
  input  wire logic [2:0]           h_i,
  input  wire logic [IdxW-1:0]      m_i,
  input  wire logic                 periodic_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [SW-1:0] node_value_i,
  output logic signed [SW-1:0]      tap_o [TapCount],
  output coef_t                     coef_o [TapCount],
  output ctl_t                      ctl_o,
  output logic                      more_o
);

  typedef enum logic [1:0] {
    SG_COPY,
    SG_HEAD,
    SG_ROW,
    SG_END
  } seg_e;

  logic signed [SW-1:0] win_q  [WinDepth];
  logic signed [SW-1:0] head_q [HeadDepth];
  logic [IdxW-1:0]      cnt_node_q;
  logic [IdxW-1:0]      jj_q;
  logic [3:0]           flags_q, flags_d, new_flags;
  logic [2:0]           cnt_q;
  seg_e                 seg;
  logic [2:0]           seg_len;
  logic                 seg_done, last_job, take;

  // job descriptor
  kind_e                job_kind;
  logic signed [PosW-1:0] job_base;
  logic                 job_neg;
  logic [1:0]           job_r;
  logic [IdxW:0]        job_idx;
  logic                 job_last;

  logic signed [PosW-1:0] sj, sm, sh, scnt, row_i;
  logic signed [PosW-1:0] pos_a [TapCount];
  logic signed [PosW-1:0] dist_a [TapCount];
  logic signed [SW-1:0]   tap_a [TapCount];
  coef_t                  coef_a [TapCount];

  assign sj   = PosW'(signed'({1'b0, jj_q}));
  assign sm   = PosW'(signed'({1'b0, m_i}));
  assign sh   = PosW'(signed'({1'b0, h_i}));
  assign scnt = PosW'(signed'({1'b0, cnt_q}));

  always_comb begin
    if (flags_q[0])      seg = SG_COPY;
    else if (flags_q[1]) seg = SG_HEAD;
    else if (flags_q[2]) seg = SG_ROW;
    else                 seg = SG_END;
  end

  always_comb begin
    case (seg)
      SG_HEAD: seg_len = h_i;
      SG_END:  seg_len = periodic_i ? 3'((4'(h_i) << 1) - 4'd1) : h_i;
      default: seg_len = 3'd1;
    endcase
  end

  assign seg_done = (cnt_q == seg_len - 3'd1);
  always_comb begin
    flags_d = flags_q;
    case (seg)
      SG_COPY: flags_d[0] = 1'b0;
      SG_HEAD: flags_d[1] = 1'b0;
      SG_ROW:  flags_d[2] = 1'b0;
      default: flags_d[3] = 1'b0;
    endcase
  end
  assign last_job = seg_done && (flags_d == 4'd0);
  assign more_o   = (flags_q != 4'd0) && !last_job;
  assign take     = in_valid_i && en_i && !more_o;
  assign in_stall_o = !(en_i && !more_o);

  // segments for node j (counter before update)
  always_comb begin
    new_flags = 4'd0;
    if (!periodic_i) begin
      new_flags[0] = (cnt_node_q == '0);
      new_flags[1] = (cnt_node_q == IdxW'({h_i, 1'b0}));
      new_flags[2] = (cnt_node_q >= IdxW'({h_i, 1'b0}));
      new_flags[3] = (cnt_node_q >= m_i);
    end else begin
      new_flags[2] = ((cnt_node_q + 1'b1) >= IdxW'({h_i, 1'b0}));
      new_flags[3] = ((cnt_node_q + 1'b1) >= m_i);
    end
  end

  always_comb begin
    job_kind = K_INNER;
    job_base = '0;
    job_neg  = 1'b0;
    job_r    = '0;
    job_idx  = '0;
    job_last = 1'b0;
    row_i    = '0;
    case (seg)
      SG_COPY: begin
        job_kind = K_COPY;
        job_base = sj;
      end
      SG_HEAD: begin
        if (!seg_done) begin
          job_kind = K_EDGE;
          job_r    = 2'(cnt_q + 3'd1);
          job_idx  = (IdxW+1)'(cnt_q + 3'd1);
        end else begin
          job_idx  = (IdxW+1)'(h_i);
        end
      end
      SG_ROW: begin
        if (!periodic_i) begin
          row_i    = sj - sh + 2'sd1;
          job_base = row_i - sh;
        end else begin
          row_i    = sj - sh;
          job_base = row_i - sh + 2'sd1;
        end
        job_idx = row_i[IdxW:0];
      end
      default: begin
        if (!periodic_i) begin
          if (!seg_done) begin
            job_kind = K_EDGE;
            job_r    = 2'(h_i - 3'd1 - cnt_q);
            job_base = sm;
            job_neg  = 1'b1;
            job_idx  = (IdxW+1)'(sm + 2'sd1 - PosW'(signed'({1'b0, job_r})));
          end else begin
            job_kind = K_COPY;
            job_base = sj;
            job_idx  = (IdxW+1)'(sm + 2'sd1);
            job_last = 1'b1;
          end
        end else begin
          row_i    = (cnt_q < h_i) ? (sm - sh + scnt) : (scnt - sh);
          job_base = row_i - sh + 2'sd1;
          job_idx  = row_i[IdxW:0];
          job_last = seg_done;
        end
      end
    endcase
  end

  // tap positions resolved the same way the grid boundary wraps them
  always_comb begin
    for (int t = 0; t < TapCount; t++) begin
      coef_a[t] = ntc_coef(job_kind, h_i, job_r, 4'(t));
      pos_a[t]  = job_neg ? job_base - PosW'(t) : job_base + PosW'(t);
      if (pos_a[t] < 0) pos_a[t] = pos_a[t] + sm;
      if (periodic_i && pos_a[t] >= sm) pos_a[t] = pos_a[t] - sm;
      dist_a[t] = sj - pos_a[t];
      if (coef_a[t] == '0 || pos_a[t] < 0)
        tap_a[t] = '0;
      else if (dist_a[t] >= 0 && dist_a[t] < PosW'(WinDepth))
        tap_a[t] = win_q[dist_a[t][3:0]];
      else if (pos_a[t] < PosW'(HeadDepth))
        tap_a[t] = head_q[pos_a[t][2:0]];
      else
        tap_a[t] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < WinDepth; d++) win_q[d] <= '0;
      cnt_node_q <= '0;
      jj_q       <= '0;
      flags_q    <= '0;
      cnt_q      <= '0;
      ctl_o      <= '0;
    end else begin
      if (en_i) begin
        ctl_o.valid <= (flags_q != 4'd0);
        ctl_o.idx   <= job_idx[IdxW-1:0];
        ctl_o.last  <= job_last;
      end
      if (take) begin
        for (int d = WinDepth - 1; d > 0; d--) win_q[d] <= win_q[d-1];
        win_q[0] <= node_value_i;
        jj_q     <= cnt_node_q;
        flags_q  <= new_flags;
        cnt_q    <= '0;
      end else if (en_i && flags_q != 4'd0) begin
        if (seg_done) begin
          flags_q <= flags_d;
          cnt_q   <= '0;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
      if (restart_i) begin
        cnt_node_q <= '0;
      end else if (take) begin
        if (periodic_i ? ((cnt_node_q + 1'b1) >= m_i) : (cnt_node_q >= m_i))
          cnt_node_q <= '0;
        else
          cnt_node_q <= cnt_node_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cnt_node_q < IdxW'(HeadDepth)) head_q[cnt_node_q[2:0]] <= node_value_i;
    if (en_i) begin
      tap_o  <= tap_a;
      coef_o <= coef_a;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ntc_mac.sv -----
// Nine-tap multiply, two-level registered sum, rounding and saturation,
// and the result register. Uses ntc_pkg.
`default_nettype none

module ntc_mac import ntc_pkg::*; #(
  parameter int unsigned SW = 24,
  parameter int unsigned CF = 15
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic signed [SW-1:0] tap_i [TapCount],
  input  coef_t                     coef_i [TapCount],
  input  ctl_t                      ctl_i,
  input  wire logic                 out_stall_i,
  output logic                      en_o,
  output logic                      out_valid_o,
  output logic signed [SW-1:0]      center_value_o,
  output logic [IdxW-1:0]           center_index_o,
  output logic                      last_center_o
);

  localparam int unsigned CW   = BaseCoefW + CF - BaseFrac;
  localparam int unsigned PW   = SW + CW;
  localparam int unsigned SUMW = PW + 4;

  logic signed [PW-1:0]   prod_q [TapCount];
  logic signed [SUMW-1:0] part_q [3];
  logic signed [SUMW-1:0] total, rounded;
  logic signed [SUMW-1:0] sat_hi, sat_lo;
  logic signed [CW-1:0]   coef_s [TapCount];
  ctl_t                   ctl2_q, ctl3_q;

  assign en_o = !out_valid_o || !out_stall_i;

  always_comb begin
    for (int t = 0; t < TapCount; t++)
      coef_s[t] = CW'(coef_i[t]) <<< (CF - BaseFrac);
  end

  assign total   = part_q[0] + part_q[1] + part_q[2];
  assign rounded = (total + (SUMW'(1) <<< (CF - 1))) >>> CF;
  assign sat_hi  = SUMW'({1'b0, {(SW-1){1'b1}}});
  assign sat_lo  = ~sat_hi;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      for (int t = 0; t < TapCount; t++) prod_q[t] <= PW'(tap_i[t]) * PW'(coef_s[t]);
      for (int g = 0; g < 3; g++)
        part_q[g] <= SUMW'(prod_q[3*g]) + SUMW'(prod_q[3*g+1]) + SUMW'(prod_q[3*g+2]);
      if (rounded > sat_hi)      center_value_o <= sat_hi[SW-1:0];
      else if (rounded < sat_lo) center_value_o <= sat_lo[SW-1:0];
      else                       center_value_o <= rounded[SW-1:0];
      center_index_o <= ctl3_q.idx;
      last_center_o  <= ctl3_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q      <= '0;
      ctl3_q      <= '0;
      out_valid_o <= 1'b0;
    end else if (en_o) begin
      ctl2_q      <= ctl_i;
      ctl3_q      <= ctl2_q;
      out_valid_o <= ctl3_q.valid;
    end
  end

endmodule

`default_nettype wire

// ----- tb/node_to_center_interpolator_core_test.sv -----
// Testbench of node_to_center_interpolator_core: streams node samples under
// random idling and compares each center beat against an in-bench predictor.
// Depends on rtl/ntc_pkg.sv and rtl/node_to_center_interpolator_core.sv.
`timescale 1ns / 1ps

module node_to_center_interpolator_core_test;
  import ntc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 24;
  localparam logic [1:0]  RegUnused  = 2'd3;

  typedef struct {
    logic signed [23:0] value;
    logic [IdxW-1:0]    index;
    logic               last;
  } center_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i = '0;
  logic [IdxW-1:0]         cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [23:0]      node_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [23:0]      center_value_o;
  logic [IdxW-1:0]         center_index_o;
  logic                    last_center_o;

  node_to_center_interpolator_core u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // stencil weights over 2^15
  int inner_w [4][8] = '{
    '{16384, 16384, 0, 0, 0, 0, 0, 0},
    '{-2048, 18432, 18432, -2048, 0, 0, 0, 0},
    '{384, -3200, 19200, 19200, -3200, 384, 0, 0},
    '{-80, 784, -3920, 19600, 19600, -3920, 784, -80}
  };
  int edge_w [3][3][9] = '{
    '{'{8960, 35840, -17920, 7168, -1280, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{7392, 44352, -36960, 29568, -15840, 4928, -672, 0, 0},
      '{-672, 12096, 30240, -13440, 6048, -1728, 224, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0}},
    '{'{6435, 51480, -60060, 72072, -64350, 40040, -16380, 3960, -429},
      '{-429, 10296, 36036, -24024, 18018, -10296, 4004, -936, 99},
      '{99, -1320, 13860, 27720, -11550, 5544, -1980, 440, -45}}
  };

  // predictor state
  int unsigned half_reg = 1, span_reg = 64, wrap_reg = 0;
  longint      recent [9];
  longint      head [8];
  int unsigned node_pos = 0;

  center_t     center_q [$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          node_count = 0;

  function automatic int unsigned eff_half();
    int unsigned h;
    h = half_reg;
    if (h < 1) h = 1;
    if (h > 4) h = 4;
    return h;
  endfunction

  function automatic int unsigned eff_span();
    int unsigned m, h;
    h = eff_half();
    m = span_reg;
    if (m > 1024) m = 1024;
    if (m <= 4 * h) m = 4 * h + 1;
    return m;
  endfunction

  function automatic longint node_at(longint x, int unsigned m);
    longint d;
    if (x < 0) x += m;
    if (x >= m && wrap_reg != 0) x -= m;
    if (x < 0) return 0;
    d = longint'(node_pos) - x;
    if (d >= 0 && d < 9) return recent[d];
    if (x < 8) return head[x];
    return 0;
  endfunction

  function automatic logic signed [23:0] round_sat(longint acc);
    longint v;
    v = (acc + 16384) >>> 15;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic logic signed [23:0] inner_row(longint first, int unsigned h,
                                                   int unsigned m);
    longint acc;
    acc = 0;
    for (int t = 0; t < 2 * h; t++) acc += longint'(inner_w[h-1][t]) * node_at(first + t, m);
    return round_sat(acc);
  endfunction

  function automatic logic signed [23:0] edge_row(int unsigned h, int unsigned r,
                                                  int unsigned m, bit tail);
    longint acc;
    longint x;
    acc = 0;
    for (int t = 0; t <= 2 * h; t++) begin
      x = tail ? longint'(m) - t : longint'(t);
      acc += longint'(edge_w[h-2][r-1][t]) * node_at(x, m);
    end
    return round_sat(acc);
  endfunction

  function automatic void push_center(logic signed [23:0] v, int unsigned idx, bit last);
    center_t c;
    c.value = v;
    c.index = idx[IdxW-1:0];
    c.last  = last;
    center_q.push_back(c);
  endfunction

  function automatic void predict_centers(logic signed [23:0] raw);
    longint      x;
    int unsigned h, m, j, i;
    x = raw;
    for (int d = 8; d > 0; d--) recent[d] = recent[d-1];
    recent[0] = x;
    j = node_pos;
    if (j < 8) head[j] = x;
    h = eff_half();
    m = eff_span();
    if (wrap_reg == 0) begin
      if (j == 0) push_center(raw, 0, 0);
      if (j == 2 * h) begin
        for (int unsigned r = 1; r < h; r++) push_center(edge_row(h, r, m, 0), r, 0);
        push_center(inner_row(0, h, m), h, 0);
      end
      if (j >= 2 * h) begin
        i = j - h + 1;
        if (i <= m + 1 - h) push_center(inner_row(longint'(i) - h, h, m), i, 0);
      end
      if (j >= m) begin
        for (int r = int'(h) - 1; r >= 1; r--)
          push_center(edge_row(h, r, m, 1), m + 1 - r, 0);
        push_center(raw, m + 1, 1);
        node_pos = 0;
      end else begin
        node_pos = j + 1;
      end
    end else begin
      if (j + 1 >= 2 * h) begin
        i = j - h;
        push_center(inner_row(longint'(i) - h + 1, h, m), i, 0);
      end
      if (j + 1 >= m) begin
        for (i = m - h; i < m; i++) push_center(inner_row(longint'(i) - h + 1, h, m), i, 0);
        for (i = 0; i + 2 <= h; i++) push_center(inner_row(longint'(i) - h + 1, h, m), i, 0);
        center_q[center_q.size()-1].last = 1'b1;
        node_pos = 0;
      end else begin
        node_pos = j + 1;
      end
    end
  endfunction

  // one node beat; waits for the edge that takes it, then at random drops valid and idles
  task automatic send_node(logic signed [23:0] v);
    node_value_i <= v;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_centers(v);
    node_count++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (center_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [IdxW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegOrderHalf: begin half_reg = data & 7; node_pos = 0; end
      RegIntervals: begin span_reg = data; node_pos = 0; end
      RegPeriodic:  begin wrap_reg = data & 1; node_pos = 0; end
      default: ;
    endcase
  endtask

  function automatic logic signed [23:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(signed'($urandom_range(0, 64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // node count of one full pass at the current setting
  function automatic int pass_len();
    return (wrap_reg != 0) ? eff_span() : eff_span() + 1;
  endfunction

  task automatic test_reset_state();
    send_node(24'sh7FFFFF);
    send_node(24'sh800000);
    send_node(24'sh000001);
    send_node(24'shFFFFFF);
    settle();
  endtask

  task automatic test_saturating_edges();
    // order 8 boundary rows with alternating full-scale nodes overflow
    write_reg(RegOrderHalf, 11'd4);
    write_reg(RegIntervals, 11'd0);
    for (int n = 0; n < 18; n++) send_node(n[0] ? 24'sh800000 : 24'sh7FFFFF);
    settle();
  endtask

  task automatic test_wrapped_small();
    // half order 0 acts as half order 1; ignored register index must not restart
    write_reg(RegOrderHalf, 11'd0);
    write_reg(RegPeriodic, 11'd1);
    write_reg(RegIntervals, 11'd1);
    send_node(24'sh123456);
    send_node(24'sh800000);
    settle();
    write_reg(RegUnused, 11'h7FF);
    send_node(24'sh7FFFFF);
    send_node(24'sh000000);
    send_node(24'shABCDEF);
    settle();
  endtask

  task automatic test_random_passes();
    int len;
    while (node_count < 170) begin
      write_reg(RegOrderHalf, 11'($urandom_range(0, 7)));
      write_reg(RegPeriodic, 11'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) begin
        // a count of 1024 or an oversized one that clamps to 1024; only part of that pass is sent
        write_reg(RegIntervals, ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'd1024);
        len = 25;
      end else begin
        write_reg(RegIntervals, 11'($urandom_range(0, 40)));
        len = pass_len();
        if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
      end
      for (int n = 0; n < len; n++) send_node(pick_value());
      settle();
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    write_reg(RegOrderHalf, 11'd3);
    write_reg(RegPeriodic, 11'd1);
    write_reg(RegIntervals, 11'd13);
    for (int n = 0; n < pass_len(); n++) send_node(pick_value());
    settle();
  endtask

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(1, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    center_t exp_c;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (center_q.size() == 0) begin
        $display("%0t: unexpected center beat value %0d index %0d", $time,
                 center_value_o, center_index_o);
        errors++;
      end else begin
        exp_c = center_q.pop_front();
        if (center_value_o !== exp_c.value) begin
          $display("%0t: center_value expected %0d actual %0d", $time, exp_c.value,
                   center_value_o);
          errors++;
        end
        if (center_index_o !== exp_c.index) begin
          $display("%0t: center_index expected %0d actual %0d", $time, exp_c.index,
                   center_index_o);
          errors++;
        end
        if (last_center_o !== exp_c.last) begin
          $display("%0t: last_center expected %0d actual %0d", $time, exp_c.last,
                   last_center_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL node_to_center_interpolator_core");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_saturating_edges();
    test_wrapped_small();
    test_random_passes();
    test_back_to_back();
    if (errors == 0 && center_q.size() == 0) begin
      $display("PASS node_to_center_interpolator_core");
    end else begin
      $display("FAIL node_to_center_interpolator_core");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ntc_pkg.sv
rtl/ntc_seq.sv
rtl/ntc_mac.sv
rtl/node_to_center_interpolator_core.sv
tb/node_to_center_interpolator_core_test.sv
